[hdl/dq_pkg.sv]
// Shared types and constants for the double-ended queue core.
package dq_pkg;

   localparam int DATA_W       = 32;
   localparam int CAPACITY_DEF = 16;
   localparam int COUNT_OUT_W  = 5;

   // Marker reported for front and rear when the queue is empty
   localparam logic signed [DATA_W-1:0] EMPTY_MARK = '1;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4,
      CMD_CLEAR      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY_POP = 2'd1,
      ST_FULL_PUSH = 2'd2
   } status_type;

   // Operation broadcast to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD      = 3'd0,
      CELL_SHIFT_IN  = 3'd1,
      CELL_SHIFT_OUT = 3'd2,
      CELL_APPEND    = 3'd3,
      CELL_TRIM      = 3'd4,
      CELL_CLEAR     = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

[hdl/dq_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface dq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [31:0] push_value;

   modport source (output valid, output command, output push_value, input ready);
   modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface dq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] popped_value;
   logic signed [31:0] front_value;
   logic signed [31:0] rear_value;
   logic               is_empty;
   logic [4:0]         element_count;

   modport source (output valid, output status, output popped_value, output front_value,
                   output rear_value, output is_empty, output element_count, input ready);
   modport sink   (input valid, input status, input popped_value, input front_value,
                   input rear_value, input is_empty, input element_count, output ready);
endinterface

[hdl/double_ended_queue_core.sv]
// Top level of the double-ended queue core: command decode, cell row and response stage.
//
// Usage: each transfer on the req channel carries a command (none, push front,
// push back, pop front, pop back, clear) and a push value. For each request one
// transfer leaves on the rsp channel with the status, the popped value, the front
// and rear values (-1 when empty), the empty flag and the element count (mod 32).
// Elements live in a row of CAPACITY cells, front at cell 0; pushes and pops at
// the front shift the whole row by one cell.
// A request is applied to the row when it is taken; its status and popped value
// are parked in the pending register, then moved with the row's front, rear,
// empty flag and count into the response register, which drives rsp valid.
// Throughput: one request per cycle while rsp ready stays high; the rear value
// comes through a select chain across all cells, which sets the cycle time.
// Reset: the queue is empty and no response is pending; cell contents are not
// cleared, only their occupied bits.
// Stall: while rsp ready is low the last response holds; one more request can be
// taken and parked, after which req ready stays low until the response moves.
module double_ended_queue_core #(
   parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
   input  logic     clock,
   input  logic     reset,
   dq_req_if.sink   req_ch,
   dq_rsp_if.source rsp_ch
);
   import dq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                     req_fire;
   logic                     move;
   cmd_type                  cmd;
   cell_ctrl_type            ctrl;
   status_type               status;
   logic signed [DATA_W-1:0] popped;
   logic                     full;
   logic                     empty;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     pend_ff, pend_in;
   status_type               pend_status_ff;
   logic signed [DATA_W-1:0] pend_popped_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_popped_ff;
   logic signed [DATA_W-1:0] rsp_front_ff;
   logic signed [DATA_W-1:0] rsp_rear_ff;
   logic                     rsp_empty_ff;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;

   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]      cell_occ;
   logic signed [DATA_W-1:0] rear_link  [CAPACITY+1];

   // Handshake: a parked result may leave while a new request comes in
   assign move         = pend_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !pend_ff || move;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign cmd   = cmd_type'(req_ch.command);
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // Decode the command into a row operation, status and popped value
   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.value = req_ch.push_value;
      status     = ST_OK;
      popped     = '0;
      count_in   = count_ff;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL_PUSH;
            end else begin
               ctrl.op  = CELL_SHIFT_IN;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL_PUSH;
            end else begin
               ctrl.op  = CELL_APPEND;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY_POP;
            end else begin
               ctrl.op  = CELL_SHIFT_OUT;
               popped   = cell_value[0];
               count_in = count_ff - 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY_POP;
            end else begin
               ctrl.op  = CELL_TRIM;
               popped   = rear_link[0];
               count_in = count_ff - 1'b1;
            end
         end
         CMD_CLEAR: begin
            ctrl.op  = CELL_CLEAR;
            count_in = '0;
         end
         default: begin
         end
      endcase
      if (!req_fire) begin
         ctrl.op  = CELL_HOLD;
         count_in = count_ff;
      end
   end

   // Row of cells; the left edge feeds the push value, the right edge is free
   assign rear_link[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] lv;
      logic                     lo;
      logic signed [DATA_W-1:0] rv;
      logic                     ro;

      if (i == 0) begin : g_left_edge
         assign lv = req_ch.push_value;
         assign lo = 1'b1;
      end else begin : g_left_inner
         assign lv = cell_value[i-1];
         assign lo = cell_occ[i-1];
      end

      if (i == CAPACITY - 1) begin : g_right_edge
         assign rv = '0;
         assign ro = 1'b0;
      end else begin : g_right_inner
         assign rv = cell_value[i+1];
         assign ro = cell_occ[i+1];
      end

      dq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_value  (lv),
         .left_occ    (lo),
         .right_value (rv),
         .right_occ   (ro),
         .rear_in     (rear_link[i+1]),
         .value       (cell_value[i]),
         .occ         (cell_occ[i]),
         .rear_out    (rear_link[i])
      );
   end

   // Park status and popped value until the response stage takes them
   always_comb begin
      pend_in = pend_ff;
      if (move) begin
         pend_in = 1'b0;
      end
      if (req_fire) begin
         pend_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the parked result together with the row as it now stands
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_status_ff <= status;
         pend_popped_ff <= popped;
      end
      if (move) begin
         rsp_status_ff <= pend_status_ff;
         rsp_popped_ff <= pend_popped_ff;
         rsp_front_ff  <= empty ? EMPTY_MARK : cell_value[0];
         rsp_rear_ff   <= empty ? EMPTY_MARK : rear_link[0];
         rsp_empty_ff  <= empty;
         rsp_count_ff  <= COUNT_OUT_W'(count_ff);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.popped_value  = rsp_popped_ff;
   assign rsp_ch.front_value   = rsp_front_ff;
   assign rsp_ch.rear_value    = rsp_rear_ff;
   assign rsp_ch.is_empty      = rsp_empty_ff;
   assign rsp_ch.element_count = rsp_count_ff;

endmodule

[hdl/dq_cell.sv]
// One storage cell of the queue row: a value, an occupied bit and a rear-select link.
module dq_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  dq_pkg::cell_ctrl_type            ctrl,
   input  logic signed [dq_pkg::DATA_W-1:0] left_value,
   input  logic                             left_occ,
   input  logic signed [dq_pkg::DATA_W-1:0] right_value,
   input  logic                             right_occ,
   input  logic signed [dq_pkg::DATA_W-1:0] rear_in,
   output logic signed [dq_pkg::DATA_W-1:0] value,
   output logic                             occ,
   output logic signed [dq_pkg::DATA_W-1:0] rear_out
);
   import dq_pkg::*;

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     occ_ff, occ_in;
   logic                     is_tail;

   // This cell holds the rear element when its right neighbor is free
   assign is_tail  = occ_ff && !right_occ;
   assign rear_out = is_tail ? value_ff : rear_in;

   // Select next contents from the broadcast operation and the neighbors
   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      case (ctrl.op)
         CELL_SHIFT_IN: begin
            value_in = left_value;
            occ_in   = left_occ;
         end
         CELL_SHIFT_OUT: begin
            value_in = right_value;
            occ_in   = right_occ;
         end
         CELL_APPEND: begin
            if (left_occ && !occ_ff) begin
               value_in = ctrl.value;
               occ_in   = 1'b1;
            end
         end
         CELL_TRIM: begin
            if (is_tail) begin
               occ_in = 1'b0;
            end
         end
         CELL_CLEAR: begin
            occ_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign value = value_ff;
   assign occ   = occ_ff;

endmodule

[test/dq_scoreboard.sv]
// Scoreboard for the double-ended queue core: mirrors the queue and checks every response.
module dq_scoreboard (
   input  logic clock,
   input  logic reset,
   dq_req_if    req_mon,
   dq_rsp_if    rsp_mon,
   output int   fail_count,
   output int   pending
);
   import dq_pkg::*;

   localparam int DEPTH = CAPACITY_DEF;

   typedef struct packed {
      status_type                    status;
      logic signed [DATA_W-1:0]      popped;
      logic signed [DATA_W-1:0]      front;
      logic signed [DATA_W-1:0]      rear;
      logic                          empty;
      logic [COUNT_OUT_W-1:0]        count;
   } dq_outcome_type;

   // Mirror of the queue: circular store, front index and fill level
   logic signed [DATA_W-1:0] slot_mirror [DEPTH];
   int                       head_pos;
   int                       fill_level;
   dq_outcome_type           outcome_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      head_pos   = 0;
      fill_level = 0;
   end

   // Apply one command to the mirror and return the response it must produce
   function automatic dq_outcome_type apply_command(input logic [2:0] cmd,
                                                    input logic signed [DATA_W-1:0] val);
      dq_outcome_type res;
      int             pos;
      res.status = ST_OK;
      res.popped = '0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (fill_level >= DEPTH) begin
               res.status = ST_FULL_PUSH;
            end else begin
               head_pos = (head_pos + DEPTH - 1) % DEPTH;
               slot_mirror[head_pos] = val;
               fill_level++;
            end
         end
         CMD_PUSH_BACK: begin
            if (fill_level >= DEPTH) begin
               res.status = ST_FULL_PUSH;
            end else begin
               pos = (head_pos + fill_level) % DEPTH;
               slot_mirror[pos] = val;
               fill_level++;
            end
         end
         CMD_POP_FRONT: begin
            if (fill_level == 0) begin
               res.status = ST_EMPTY_POP;
            end else begin
               res.popped = slot_mirror[head_pos];
               head_pos   = (head_pos + 1) % DEPTH;
               fill_level--;
            end
         end
         CMD_POP_BACK: begin
            if (fill_level == 0) begin
               res.status = ST_EMPTY_POP;
            end else begin
               pos        = (head_pos + fill_level - 1) % DEPTH;
               res.popped = slot_mirror[pos];
               fill_level--;
            end
         end
         CMD_CLEAR: begin
            head_pos   = 0;
            fill_level = 0;
         end
         default: ;
      endcase
      if (fill_level == 0) begin
         res.front = EMPTY_MARK;
         res.rear  = EMPTY_MARK;
         res.empty = 1'b1;
      end else begin
         res.front = slot_mirror[head_pos];
         res.rear  = slot_mirror[(head_pos + fill_level - 1) % DEPTH];
         res.empty = 1'b0;
      end
      res.count = COUNT_OUT_W'(fill_level);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("mismatch at %0t: %s got %0h, want %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   // Predict on each request transfer, then check each response transfer
   always @(posedge clock) begin
      dq_outcome_type want;
      if (reset) begin
         head_pos   = 0;
         fill_level = 0;
         outcome_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            outcome_q.push_back(apply_command(req_mon.command, req_mon.push_value));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("response with no request waiting", rsp_mon.popped_value,
                               '0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_mon.status), DATA_W'(want.status));
               if (rsp_mon.popped_value !== want.popped)
                  report_mismatch("popped_value", rsp_mon.popped_value, want.popped);
               if (rsp_mon.front_value !== want.front)
                  report_mismatch("front_value", rsp_mon.front_value, want.front);
               if (rsp_mon.rear_value !== want.rear)
                  report_mismatch("rear_value", rsp_mon.rear_value, want.rear);
               if (rsp_mon.is_empty !== want.empty)
                  report_mismatch("is_empty", DATA_W'(rsp_mon.is_empty), DATA_W'(want.empty));
               if (rsp_mon.element_count !== want.count)
                  report_mismatch("element_count", DATA_W'(rsp_mon.element_count),
                                  DATA_W'(want.count));
            end
         end
      end
      pending = outcome_q.size();
   end

endmodule

[test/tb_top.sv]
// Testbench top for the double-ended queue core: clock, reset, stimulus and verdict.
module tb_top;
   import dq_pkg::*;

   // Command codes the block treats as none
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int         PHASES       = 13;
   localparam int         PHASE_ITEMS  = 50;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   logic req_no_idle;
   logic rsp_no_idle;

   dq_req_if req_ch ();
   dq_rsp_if rsp_ch ();

   double_ended_queue_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dq_scoreboard scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the handshakes hang
   initial begin
      #1_000_000;
      $display("** double_ended_queue_core: FAILED **");
      $finish;
   end

   // Offer one request after a random gap (none while req_no_idle is set) and hold it until the transfer
   task automatic drive_request(input logic [2:0] cmd, input logic signed [DATA_W-1:0] val);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.push_value <= val;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Response side: stall a random number of cycles before each transfer, none while rsp_no_idle is set
   initial begin
      int wait_cycles;
      int taken;
      rsp_ch.ready = 1'b0;
      rsp_no_idle  = 1'b0;
      taken        = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 64 == 0)
            rsp_no_idle = ($urandom_range(0, 3) == 0);
         wait_cycles = rsp_no_idle ? 0 : $urandom_range(0, 7);
         if (wait_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
         @(negedge clock);
      end
   end

   // Stimulus: directed corner cases, then phases biased toward filling, draining or neither
   initial begin
      int                       push_pct;
      int                       pick;
      logic [2:0]               cmd;
      logic signed [DATA_W-1:0] val;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = CMD_NONE;
      req_ch.push_value = '0;
      req_no_idle       = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty-queue corners and unused codes
      drive_request(CMD_POP_FRONT, 32'sd5);
      drive_request(CMD_POP_BACK, 32'sd7);
      drive_request(CMD_SPARE_LO, 32'sd1);
      drive_request(CMD_SPARE_HI, 32'sd2);
      drive_request(CMD_CLEAR, 32'sd0);
      // extremes of the value at both ends, front push wraps the head
      drive_request(CMD_PUSH_FRONT, 32'h8000_0000);
      drive_request(CMD_PUSH_BACK, 32'h7FFF_FFFF);
      drive_request(CMD_PUSH_FRONT, -32'sd1);
      drive_request(CMD_PUSH_BACK, 32'sd0);
      drive_request(CMD_POP_FRONT, 32'sd0);
      drive_request(CMD_POP_BACK, 32'sd0);
      // fill to capacity, then refused pushes at both ends
      for (int i = 0; i < CAPACITY_DEF - 2; i++)
         drive_request((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
      drive_request(CMD_PUSH_FRONT, $urandom);
      drive_request(CMD_PUSH_BACK, $urandom);
      drive_request(CMD_CLEAR, $urandom);

      for (int ph = 0; ph < PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0:       push_pct = 20;
            1:       push_pct = 50;
            2:       push_pct = 75;
            default: push_pct = 92;
         endcase
         req_no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
               cmd = CMD_CLEAR;
            else if (pick < 5)
               cmd = CMD_NONE + 3'($urandom_range(0, 1)) * CMD_SPARE_LO;
            else if (pick < 6)
               cmd = CMD_SPARE_HI;
            else if ($urandom_range(0, 99) < push_pct)
               cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            else
               cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            case ($urandom_range(0, 9))
               0:       val = 32'h8000_0000;
               1:       val = 32'h7FFF_FFFF;
               2:       val = -32'sd1;
               default: val = $urandom;
            endcase
            drive_request(cmd, val);
         end
      end

      // Drop valid, drain the outstanding responses, then watch for stray ones
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("** double_ended_queue_core: PASSED **");
      else
         $display("** double_ended_queue_core: FAILED **");
      $finish;
   end

endmodule

[filelist.f]
hdl/dq_pkg.sv
hdl/dq_if.sv
hdl/dq_cell.sv
hdl/double_ended_queue_core.sv
test/dq_scoreboard.sv
test/tb_top.sv
